[hdl/round_robin_matching_scheduler_defines.svh]
// assertion macros for the round-robin matching scheduler checker
// no dependencies; included by the checker file only
`ifndef ROUND_ROBIN_MATCHING_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_MATCHING_SCHEDULER_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define RRMS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rrms assertion failed");

// property checked on every rising clock edge, reset included
`define RRMS_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("rrms assertion failed");

`endif

[hdl/rrms_pkg.sv]
// shared constants for the round-robin matching scheduler
// no dependencies; used by the top level and the checker
`default_nettype none

package rrms_pkg;

   // width of one bitmap field on the streams
   localparam int unsigned FIELD_W = 16;
   // request stream data: request_bits
   localparam int unsigned REQ_DATA_W = FIELD_W;
   // result stream data: grant_bits, match_bits
   localparam int unsigned RSP_DATA_W = 2 * FIELD_W;

endpackage

`default_nettype wire

[hdl/rrms_arbiter.sv]
// round-robin arbiter lane: first request at or after the pointer
// no dependencies; instantiated by rrms_phase
`default_nettype none

module rrms_arbiter #(
   parameter int unsigned NUM_PORTS = 4
) (
   input  logic [NUM_PORTS-1:0]         req,
   input  logic [$clog2(NUM_PORTS)-1:0] ptr,
   output logic [NUM_PORTS-1:0]         gnt,
   output logic                         found,
   output logic [$clog2(NUM_PORTS)-1:0] next_ptr
);

   localparam int unsigned PTR_W = $clog2(NUM_PORTS);

   // scan the candidates in rotating order from the pointer
   always_comb begin : scan
      logic [PTR_W:0]   sum;
      logic [PTR_W:0]   nxt;
      logic [PTR_W-1:0] idx;
      sum      = '0;
      nxt      = '0;
      idx      = '0;
      found    = 1'b0;
      gnt      = '0;
      next_ptr = ptr;
      for (int n = 0; n < NUM_PORTS; n++) begin
         sum = {1'b0, ptr} + (PTR_W+1)'(n);
         if (sum >= (PTR_W+1)'(NUM_PORTS)) begin
            sum = sum - (PTR_W+1)'(NUM_PORTS);
         end
         idx = sum[PTR_W-1:0];
         if (!found && req[idx]) begin
            found    = 1'b1;
            gnt[idx] = 1'b1;
            nxt      = {1'b0, idx} + (PTR_W+1)'(1);
            // one beyond the last port wraps to zero
            if (nxt >= (PTR_W+1)'(NUM_PORTS)) begin
               next_ptr = '0;
            end else begin
               next_ptr = nxt[PTR_W-1:0];
            end
         end
      end
   end

endmodule

`default_nettype wire

[hdl/rrms_phase.sv]
// one matching phase: a row of arbiter lanes with their pointer registers
// depends on rrms_arbiter
`default_nettype none

module rrms_phase #(
   parameter int unsigned NUM_PORTS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             update,
   input  logic [NUM_PORTS*NUM_PORTS-1:0]   lane_req,
   output logic [NUM_PORTS*NUM_PORTS-1:0]   lane_gnt
);

   localparam int unsigned PTR_W = $clog2(NUM_PORTS);

   logic [PTR_W-1:0] ptr_ff [NUM_PORTS];
   logic [PTR_W-1:0] ptr_in [NUM_PORTS];
   logic             found  [NUM_PORTS];

   for (genvar l = 0; l < NUM_PORTS; l++) begin : g_lane
      rrms_arbiter #(
         .NUM_PORTS (NUM_PORTS)
      ) u_arbiter (
         .req      (lane_req[l*NUM_PORTS +: NUM_PORTS]),
         .ptr      (ptr_ff[l]),
         .gnt      (lane_gnt[l*NUM_PORTS +: NUM_PORTS]),
         .found    (found[l]),
         .next_ptr (ptr_in[l])
      );

      // pointer moves only when its lane picked something
      always_ff @(posedge clock) begin
         if (reset) begin
            ptr_ff[l] <= '0;
         end else if (update && found[l]) begin
            ptr_ff[l] <= ptr_in[l];
         end
      end
   end

endmodule

`default_nettype wire

[hdl/round_robin_matching_scheduler.sv]
// round-robin matching scheduler, top level
// depends on rrms_pkg and rrms_phase
//
// usage:
//   req_* carries one request matrix per transaction (bit i*N+j: input i
//   has a cell for output j). rsp_* returns the grant matrix in the low 16
//   bits and the accept matrix in the high 16 bits of tdata.
//   an accepted request is registered in the grant stage, then in the output
//   register that drives rsp_tvalid. the grant phase runs in the first stage
//   with its per-output pointers, the accept phase runs in the second stage
//   with its per-input pointers, so neither pointer loop spans both stages.
//   throughput: one matrix per cycle while rsp_tready stays high.
//   a stalled receiver holds the output register; the grant stage keeps
//   accepting until it is full too, then req_tready drops.
//   reset (synchronous, active high) empties both stages and sets all
//   pointers to zero.
//   request bits above N*N are ignored; with N above 4 only the low 16
//   bits of each matrix reach the result.
`default_nettype none

module round_robin_matching_scheduler #(
   parameter int unsigned NUM_PORTS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // request_bits [15:0]
   input  logic [rrms_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // grant_bits [15:0], match_bits [31:16]
   output logic [rrms_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int unsigned MAT_W = NUM_PORTS * NUM_PORTS;
   localparam int unsigned FW    = rrms_pkg::FIELD_W;

   logic [MAT_W+FW-1:0] req_ext;
   logic [MAT_W-1:0]    req_mat;
   logic [MAT_W-1:0]    glane_req;
   logic [MAT_W-1:0]    glane_gnt;
   logic [MAT_W-1:0]    gnt_mat;
   logic [MAT_W-1:0]    acc_mat;
   logic [MAT_W+FW-1:0] gnt_ext;
   logic [MAT_W+FW-1:0] acc_ext;

   logic             s1_valid_ff;
   logic [MAT_W-1:0] s1_gnt_ff;
   logic             out_valid_ff;
   logic [FW-1:0]    out_gnt_ff;
   logic [FW-1:0]    out_acc_ff;

   logic req_fire;
   logic s2_load;

   // handshake and stage advance
   assign s2_load    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s2_load;
   assign req_fire   = req_tvalid && req_tready;

   // zero-extend the request field to the full matrix
   assign req_ext = {{MAT_W{1'b0}}, req_tdata};
   assign req_mat = req_ext[MAT_W-1:0];

   // grant lanes are per output: transpose in and out
   for (genvar i = 0; i < NUM_PORTS; i++) begin : g_row
      for (genvar j = 0; j < NUM_PORTS; j++) begin : g_col
         assign glane_req[j*NUM_PORTS+i] = req_mat[i*NUM_PORTS+j];
         assign gnt_mat[i*NUM_PORTS+j]   = glane_gnt[j*NUM_PORTS+i];
      end
   end

   // grant phase, one lane per output
   rrms_phase #(
      .NUM_PORTS (NUM_PORTS)
   ) u_grant (
      .clock    (clock),
      .reset    (reset),
      .update   (req_fire),
      .lane_req (glane_req),
      .lane_gnt (glane_gnt)
   );

   // accept phase, one lane per input, fed from the grant register
   rrms_phase #(
      .NUM_PORTS (NUM_PORTS)
   ) u_accept (
      .clock    (clock),
      .reset    (reset),
      .update   (s2_load),
      .lane_req (s1_gnt_ff),
      .lane_gnt (acc_mat)
   );

   // trim both matrices to the output field width
   assign gnt_ext = {{FW{1'b0}}, s1_gnt_ff};
   assign acc_ext = {{FW{1'b0}}, acc_mat};

   // stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s2_load) begin
            s1_valid_ff <= 1'b0;
         end
         if (s2_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_gnt_ff <= gnt_mat;
      end
      if (s2_load) begin
         out_gnt_ff <= gnt_ext[FW-1:0];
         out_acc_ff <= acc_ext[FW-1:0];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_acc_ff, out_gnt_ff};

endmodule

`default_nettype wire

[hdl/rrms_checker.sv]
// port-level checker for the round-robin matching scheduler, with its bind
// depends on rrms_pkg and round_robin_matching_scheduler_defines.svh
`default_nettype none
`include "round_robin_matching_scheduler_defines.svh"

module rrms_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [rrms_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [rrms_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int unsigned FW = rrms_pkg::FIELD_W;

   logic [FW-1:0] grant_bits;
   logic [FW-1:0] match_bits;

   assign grant_bits = rsp_tdata[FW-1:0];
   assign match_bits = rsp_tdata[2*FW-1:FW];

   // every accept answers a grant
   `RRMS_ASSERT(a_match_in_grant, clock, reset, rsp_tvalid |-> ((match_bits & ~grant_bits) == '0))
   // any grant leads to at least one accept, and none without grants
   `RRMS_ASSERT(a_grant_gives_match, clock, reset, rsp_tvalid |-> ((grant_bits == '0) == (match_bits == '0)))
   // stalled result transaction holds its data
   `RRMS_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
   // reset empties the pipeline
   `RRMS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (!rsp_tvalid && req_tready))

endmodule

bind round_robin_matching_scheduler rrms_checker u_rrms_checker (.*);

`default_nettype wire

[sim/round_robin_matching_scheduler_test.sv]
// self-checking testbench for round_robin_matching_scheduler: request matrices are
// streamed in and each grant/accept result is checked against a behavioural predictor
// depends on rrms_pkg and the scheduler rtl only
`default_nettype none

module round_robin_matching_scheduler_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PORTS = 4;
   localparam int unsigned FW = rrms_pkg::FIELD_W;
   // the longest legitimate quiet stretch is the receiver hold-off (HOLD_CYCLES)
   // or a long random gap at 88 percent idling; this leaves a wide margin
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;
   // pipeline is two deep, so waiting SETTLE_CYCLES is enough to catch stray results
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 60;

   // result layout on rsp_tdata, low bits first: grant_bits, match_bits
   typedef struct packed {
      logic [FW-1:0] match_bits;
      logic [FW-1:0] grant_bits;
   } matching_type;

   typedef struct {
      logic [FW-1:0] request_bits;
      matching_type  result;
   } matching_due_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // request_bits [15:0]
   logic [rrms_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // grant_bits [15:0], match_bits [31:16]
   logic [rrms_pkg::RSP_DATA_W-1:0] rsp_tdata;

   // predictor state: per-output grant pointers, per-input accept pointers
   int unsigned grant_ptr [PORTS];
   int unsigned accept_ptr [PORTS];

   logic [FW-1:0]    request_backlog [$];
   matching_due_type matching_due [$];

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_rx = 1'b0;
   bit  req_taken = 1'b0;
   int  requests_queued = 0;
   int  requests_taken = 0;
   int  matchings_checked = 0;
   int  input_stall_cycles = 0;
   int  error_count = 0;
   int  idle_cycles = 0;

   round_robin_matching_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one rrm iteration: outputs grant, then inputs accept, pointers advance
   function automatic matching_type schedule_cell(input logic [FW-1:0] request_bits);
      matching_type m;
      int unsigned  cand;
      bit           found;
      m = '0;
      for (int unsigned o = 0; o < PORTS; o++) begin
         cand = grant_ptr[o];
         found = 1'b0;
         for (int unsigned n = 0; n < PORTS; n++) begin
            if (!found && request_bits[cand * PORTS + o]) begin
               m.grant_bits[cand * PORTS + o] = 1'b1;
               grant_ptr[o] = (cand + 1) % PORTS;
               found = 1'b1;
            end
            cand = (cand + 1) % PORTS;
         end
      end
      for (int unsigned i = 0; i < PORTS; i++) begin
         cand = accept_ptr[i];
         found = 1'b0;
         for (int unsigned n = 0; n < PORTS; n++) begin
            if (!found && m.grant_bits[i * PORTS + cand]) begin
               m.match_bits[i * PORTS + cand] = 1'b1;
               accept_ptr[i] = (cand + 1) % PORTS;
               found = 1'b1;
            end
            cand = (cand + 1) % PORTS;
         end
      end
      return m;
   endfunction

   // mix of uniform, sparse and dense matrices
   function automatic logic [FW-1:0] random_request();
      logic [FW-1:0] sparse;
      sparse = (FW'(1) << $urandom_range(FW - 1)) | (FW'(1) << $urandom_range(FW - 1));
      case ($urandom_range(3))
         0, 1: return FW'($urandom);
         2: return sparse;
         default: return ~sparse;
      endcase
   endfunction

   // request driver: launches the next backlog entry once the slot is free
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata <= request_backlog.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result receiver: random stalls, or held off entirely under pressure
   always @(negedge clock) begin
      if (reset || hold_rx) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor: predict on each request transaction, check each result transaction
   always @(posedge clock) begin : monitor
      matching_due_type due;
      matching_type     got;
      if (!reset) begin
         req_taken = req_tvalid && req_tready;
         if (req_tvalid && !req_tready)
            input_stall_cycles++;
         if (req_taken) begin
            due.request_bits = req_tdata;
            due.result = schedule_cell(req_tdata);
            matching_due.push_back(due);
            requests_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            matchings_checked++;
            if (matching_due.size() == 0) begin
               if (error_count < MAX_REPORTS)
                  $display("unexpected result: grant %h match %h",
                           got.grant_bits, got.match_bits);
               error_count++;
            end else begin
               due = matching_due.pop_front();
               if (got.grant_bits !== due.result.grant_bits ||
                   got.match_bits !== due.result.match_bits) begin
                  if (error_count < MAX_REPORTS)
                     $display({"mismatch for request %h: grant exp %h got %h, ",
                               "match exp %h got %h"},
                              due.request_bits, due.result.grant_bits, got.grant_bits,
                              due.result.match_bits, got.match_bits);
                  error_count++;
               end
            end
         end
         // watchdog on cycles with no transaction on either side
         if (req_taken || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                        idle_cycles, matching_due.size());
               $display("RESULT: ERROR");
               $finish;
            end
         end
      end
   end

   task automatic set_idling(input int send_pct, input int stall_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      recv_stall_pct = stall_pct;
   endtask

   task automatic queue_request(input logic [FW-1:0] request_bits);
      request_backlog.push_back(request_bits);
      requests_queued++;
   endtask

   task automatic queue_random(input int count);
      repeat (count) queue_request(random_request());
   endtask

   // wait until every request is taken and every result is back
   task automatic drain();
      while (requests_taken != requests_queued || matching_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      for (int k = 0; k < PORTS; k++) begin
         grant_ptr[k] = 0;
         accept_ptr[k] = 0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: empty and full matrices, corner bits, diagonals,
      // repeated contention so that both pointer sets wrap
      set_idling(0, 0);
      queue_request(16'h0000);
      queue_request(16'hFFFF);
      queue_request(16'h0001);
      queue_request(16'h8000);
      queue_request(16'h8421);
      queue_request(16'h1248);
      repeat (4) queue_request(16'h1111);
      repeat (4) queue_request(16'h000F);
      queue_request(16'hF000);
      repeat (3) queue_request(16'hFFFF);
      queue_request(16'hAAAA);
      queue_request(16'h5555);
      drain();

      // receiver held off while the sender keeps offering, so the input backs up
      set_idling(0, 0);
      hold_rx = 1'b1;
      queue_random(40);
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rx = 1'b0;
      drain();

      // random traffic under the different idling mixes
      set_idling(0, 0);
      queue_random(100);
      drain();
      set_idling(88, 0);
      queue_random(70);
      drain();
      set_idling(0, 88);
      queue_random(70);
      drain();
      set_idling(35, 35);
      queue_random(80);
      drain();
      set_idling(0, 0);
      queue_random(20);
      drain();

      if (matching_due.size() != 0) begin
         $display("%0d expected results never arrived", matching_due.size());
         error_count += matching_due.size();
      end
      $display("covered %0d request matrices and %0d matchings, %0d cycles of input %s",
               requests_taken, matchings_checked, input_stall_cycles, "back-pressure");
      $display("idling mixes: none, sender 88%%, receiver 88%%, both 35%%; failures: %0d",
               error_count);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
